// ===== hdl/uv_sphere_vertex_gen_unit_defines.svh =====
// Assertion helpers shared by the vertex generator RTL.
// All checks sample on clk_i and are off while rst_ni is low.
`ifndef UV_SPHERE_VERTEX_GEN_UNIT_DEFINES_SVH
`define UV_SPHERE_VERTEX_GEN_UNIT_DEFINES_SVH

// same-cycle implication
`define UVSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UVSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/uvsg_pkg.sv =====
package uvsg_pkg;

  localparam int DivStages = 8;
  localparam int DivBits   = 32;
  localparam int DivBps    = DivBits / DivStages;

  localparam logic [2:0] LAST_VTX = 3'd5;

  localparam logic signed [32:0] CORDIC_K_Q30 = 33'sd652032874;

  typedef enum logic [3:0] {
    CFG_DIVISIONS  = 4'd0,
    CFG_RADIUS     = 4'd1,
    CFG_TEX_WIDTH  = 4'd2,
    CFG_TEX_HEIGHT = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
  } side_t;

  // atan(2^-idx) as a fraction of a full turn, 2^32 = one turn
  function automatic logic signed [32:0] cordic_atan(input logic [4:0] idx);
    logic signed [32:0] a;
    case (idx)
      5'd0:    a = 33'sd536870912;
      5'd1:    a = 33'sd316933406;
      5'd2:    a = 33'sd167458907;
      5'd3:    a = 33'sd85004756;
      5'd4:    a = 33'sd42667331;
      5'd5:    a = 33'sd21354465;
      5'd6:    a = 33'sd10679838;
      5'd7:    a = 33'sd5340245;
      5'd8:    a = 33'sd2670163;
      5'd9:    a = 33'sd1335087;
      5'd10:   a = 33'sd667544;
      5'd11:   a = 33'sd333772;
      5'd12:   a = 33'sd166886;
      5'd13:   a = 33'sd83443;
      5'd14:   a = 33'sd41722;
      5'd15:   a = 33'sd20861;
      5'd16:   a = 33'sd10430;
      5'd17:   a = 33'sd5215;
      5'd18:   a = 33'sd2608;
      5'd19:   a = 33'sd1304;
      5'd20:   a = 33'sd652;
      5'd21:   a = 33'sd326;
      5'd22:   a = 33'sd163;
      5'd23:   a = 33'sd81;
      default: a = 33'sd0;
    endcase
    return a;
  endfunction

  // clamp to [-1.0, 1.0] in Q1.14
  function automatic logic signed [15:0] sat_unit(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd16384) begin
      r = 16'sd16384;
    end else if (v < -32'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // clamp to the 17-bit signed range
  function automatic logic signed [16:0] sat_s17(input logic signed [31:0] v);
    logic signed [16:0] r;
    if (v > 32'sd65535) begin
      r = 17'sd65535;
    end else if (v < -32'sd65536) begin
      r = -17'sd65536;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  // quad corner order: (c+1,r) (c,r) (c,r+1) (c,r+1) (c+1,r+1) (c+1,r)
  function automatic logic vtx_col_off(input logic [2:0] k);
    return (k == 3'd0) || (k == 3'd4) || (k == 3'd5);
  endfunction

  function automatic logic vtx_row_off(input logic [2:0] k);
    return (k == 3'd2) || (k == 3'd3) || (k == 3'd4);
  endfunction

endpackage

// ===== hdl/uvsg_div.sv =====
// Pipelined long division: (hi * 2^32 + lo) / den, low 32 quotient bits.
// hi must stay below 2 * den.
module uvsg_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [9:0]  hi_i,
  input  logic [31:0] lo_i,
  input  logic [8:0]  den_i,
  output logic [31:0] q_o
);

  logic [8:0]  rem_q [uvsg_pkg::DivStages];
  logic [31:0] lo_q  [uvsg_pkg::DivStages];
  logic [31:0] q_q   [uvsg_pkg::DivStages];

  logic [8:0] rem0;

  always_comb begin
    if (hi_i >= {1'b0, den_i}) begin
      rem0 = 9'(hi_i - {1'b0, den_i});
    end else begin
      rem0 = hi_i[8:0];
    end
  end

  for (genvar s = 0; s < uvsg_pkg::DivStages; s++) begin : g_stage
    logic [8:0]  rem_in;
    logic [31:0] lo_in;
    logic [31:0] q_in;
    logic [8:0]  rem_d;
    logic [31:0] lo_d;
    logic [31:0] q_d;

    if (s == 0) begin : g_first
      assign rem_in = rem0;
      assign lo_in  = lo_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign lo_in  = lo_q[s-1];
      assign q_in   = q_q[s-1];
    end

    always_comb begin
      logic [9:0] sh;
      rem_d = rem_in;
      lo_d  = lo_in;
      q_d   = q_in;
      for (int b = 0; b < uvsg_pkg::DivBps; b++) begin
        sh   = {rem_d, lo_d[31]};
        lo_d = {lo_d[30:0], 1'b0};
        if (sh >= {1'b0, den_i}) begin
          rem_d = 9'(sh - {1'b0, den_i});
          q_d   = {q_d[30:0], 1'b1};
        end else begin
          rem_d = sh[8:0];
          q_d   = {q_d[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        lo_q[s]  <= lo_d;
        q_q[s]   <= q_d;
      end
    end
  end

  assign q_o = q_q[uvsg_pkg::DivStages-1];

endmodule

// ===== hdl/uvsg_cordic.sv =====
// Rotation-mode CORDIC, one iteration per stage, quadrant folded back at the end.
// Each iteration stage is registered, and a final register holds the folded result.
module uvsg_cordic #(
  parameter int STAGES = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        angle_i,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);

  logic signed [32:0] x_q    [STAGES];
  logic signed [32:0] y_q    [STAGES];
  logic signed [32:0] z_q    [STAGES];
  logic [1:0]         quad_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic signed [32:0] x_in, y_in, z_in;
    logic [1:0]         quad_in;
    logic signed [32:0] x_d, y_d, z_d;

    if (s == 0) begin : g_first
      assign x_in    = uvsg_pkg::CORDIC_K_Q30;
      assign y_in    = '0;
      assign z_in    = $signed({3'b000, angle_i[29:0]});
      assign quad_in = angle_i[31:30];
    end else begin : g_next
      assign x_in    = x_q[s-1];
      assign y_in    = y_q[s-1];
      assign z_in    = z_q[s-1];
      assign quad_in = quad_q[s-1];
    end

    always_comb begin
      if (z_in >= 0) begin
        x_d = x_in - (y_in >>> s);
        y_d = y_in + (x_in >>> s);
        z_d = z_in - uvsg_pkg::cordic_atan(5'(s));
      end else begin
        x_d = x_in + (y_in >>> s);
        y_d = y_in - (x_in >>> s);
        z_d = z_in + uvsg_pkg::cordic_atan(5'(s));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s]    <= x_d;
        y_q[s]    <= y_d;
        z_q[s]    <= z_d;
        quad_q[s] <= quad_in;
      end
    end
  end

  // Q2.30 -> Q1.14, round half up, clamp, then apply the quadrant
  logic signed [32:0] x_r, y_r;
  logic signed [31:0] x_w, y_w;
  logic signed [15:0] c_s, s_s;
  logic signed [15:0] sin_d, cos_d;
  logic signed [15:0] sin_q, cos_q;

  always_comb begin
    x_r = x_q[STAGES-1] + 33'sd32768;
    y_r = y_q[STAGES-1] + 33'sd32768;
    x_w = $signed(x_r[32:16]);
    y_w = $signed(y_r[32:16]);
    c_s = uvsg_pkg::sat_unit(x_w);
    s_s = uvsg_pkg::sat_unit(y_w);
    case (quad_q[STAGES-1])
      2'd0: begin
        cos_d = c_s;
        sin_d = s_s;
      end
      2'd1: begin
        cos_d = -s_s;
        sin_d = c_s;
      end
      2'd2: begin
        cos_d = -c_s;
        sin_d = -s_s;
      end
      default: begin
        cos_d = s_s;
        sin_d = -c_s;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== hdl/uv_sphere_vertex_gen_unit.sv =====
// Channel | Dir | Handshake                  | Payload
// s_axis  | in  | s_axis_tvalid/tready       | tdata: column[8:0], row[16:9]
// m_axis  | out | m_axis_tvalid/tready       | tdata: pos_x/y/z, norm_x/y/z, tex_u/v; tlast
// cfg     | in  | cfg_valid_i/cfg_ready_o    | cfg_addr_i register index, cfg_wdata_i
//
// Each quad item becomes six vertices, one per cycle unless an output waits on m_axis_tready;
// the next item is taken as the last corner of the current one issues, so the corner sequencer
// is the limit. On its way to the first vertex an item passes the index and dividend stages,
// 8 divider stages, CORDIC_STAGES + 1 CORDIC stages and three multiply/round stages.
// One enable moves the whole pipeline; it halts only while an output waits on m_axis_tready.
// Reset clears the sequencer, valid bits and config registers to their defaults.
`include "uv_sphere_vertex_gen_unit_defines.svh"

module uv_sphere_vertex_gen_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // column[8:0], row[16:9], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[16:0] pos_y[33:17] pos_z[50:34] norm_x[66:51] norm_y[82:67]
  // norm_z[98:83] tex_u[114:99] tex_v[130:115], zero pad
  output logic [135:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [3:0]   cfg_addr_i,
  input  logic [15:0]  cfg_wdata_i
);

  localparam int PipeDepth = uvsg_pkg::DivStages + CORDIC_STAGES + 1;

  // ---------------- configuration ----------------
  logic [8:0]  div_q;
  logic [15:0] radius_q;
  logic [11:0] texw_q, texh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q    <= 9'd360;
      radius_q <= 16'd6400;
      texw_q   <= '0;
      texh_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        uvsg_pkg::CFG_DIVISIONS:  div_q    <= cfg_wdata_i[8:0];
        uvsg_pkg::CFG_RADIUS:     radius_q <= cfg_wdata_i;
        uvsg_pkg::CFG_TEX_WIDTH:  texw_q   <= cfg_wdata_i[11:0];
        uvsg_pkg::CFG_TEX_HEIGHT: texh_q   <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  logic [8:0] d_eff;
  logic [7:0] rows;
  logic [8:0] den_az, den_el;

  assign d_eff  = (div_q < 9'd4) ? 9'd4 : div_q;
  assign rows   = d_eff[8:1];
  assign den_az = d_eff - 9'd1;
  assign den_el = {1'b0, rows} - 9'd1;

  // ---------------- corner sequencer ----------------
  logic       adv;
  logic       m_valid_q;
  logic       busy_q;
  logic [2:0] k_q;
  logic [8:0] col_q;
  logic [7:0] row_q;
  logic       in_acc;
  logic [8:0] col_in, col_sat;
  logic [7:0] row_in, row_sat;

  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = adv && (!busy_q || (k_q == uvsg_pkg::LAST_VTX));
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign col_in  = s_axis_tdata[8:0];
  assign row_in  = s_axis_tdata[16:9];
  assign col_sat = (col_in >= d_eff) ? den_az : col_in;
  assign row_sat = (row_in >= rows) ? 8'(den_el) : row_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      k_q    <= '0;
    end else if (adv && busy_q) begin
      if (k_q == uvsg_pkg::LAST_VTX) begin
        busy_q <= 1'b0;
      end else begin
        k_q <= k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_q <= col_sat;
      row_q <= row_sat;
    end
  end

  // ---------------- S0: vertex indices ----------------
  logic       s0_valid_q, s0_last_q;
  logic [9:0] s0_i_q;
  logic [8:0] s0_j_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_last_q <= (k_q == uvsg_pkg::LAST_VTX);
      s0_i_q    <= {1'b0, col_q} + 10'(uvsg_pkg::vtx_col_off(k_q));
      s0_j_q    <= {1'b0, row_q} + 9'(uvsg_pkg::vtx_row_off(k_q));
    end
  end

  // ---------------- S1: dividends ----------------
  logic        s1_valid_q, s1_last_q;
  logic [9:0]  az_hi_q, el_hi_q;
  logic [31:0] az_lo_q, el_lo_q, u_lo_q, v_lo_q;
  logic [21:0] u_prod;
  logic [20:0] v_prod;

  assign u_prod = 22'(s0_i_q) * 22'(texw_q);
  assign v_prod = 21'(s0_j_q) * 21'(texh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_last_q <= s0_last_q;
      az_hi_q   <= s0_i_q;
      az_lo_q   <= 32'(den_az[8:1]);
      // j * 2^31: odd bit of j lands on the top of the low word
      el_hi_q   <= {2'b00, s0_j_q[8:1]};
      el_lo_q   <= {s0_j_q[0], 23'd0, den_el[8:1]};
      u_lo_q    <= {6'd0, u_prod, 4'd0} + 32'(rows);
      v_lo_q    <= {7'd0, v_prod, 4'd0} + 32'(rows[7:1]);
    end
  end

  // ---------------- dividers ----------------
  logic [31:0] az_ang, el_ang, u_quo, v_quo;

  uvsg_div u_div_az (
    .clk_i (clk_i), .en_i (adv), .hi_i (az_hi_q), .lo_i (az_lo_q),
    .den_i (den_az), .q_o (az_ang)
  );

  uvsg_div u_div_el (
    .clk_i (clk_i), .en_i (adv), .hi_i (el_hi_q), .lo_i (el_lo_q),
    .den_i (den_el), .q_o (el_ang)
  );

  uvsg_div u_div_u (
    .clk_i (clk_i), .en_i (adv), .hi_i (10'd0), .lo_i (u_lo_q),
    .den_i (d_eff), .q_o (u_quo)
  );

  uvsg_div u_div_v (
    .clk_i (clk_i), .en_i (adv), .hi_i (10'd0), .lo_i (v_lo_q),
    .den_i ({1'b0, rows}), .q_o (v_quo)
  );

  logic [15:0] u_sat, v_sat;
  assign u_sat = (|u_quo[31:16]) ? 16'hFFFF : u_quo[15:0];
  assign v_sat = (|v_quo[31:16]) ? 16'hFFFF : v_quo[15:0];

  // ---------------- side line through divider and CORDIC ----------------
  uvsg_pkg::side_t side_q [PipeDepth];

  for (genvar p = 0; p < PipeDepth; p++) begin : g_side
    uvsg_pkg::side_t side_d;

    if (p == 0) begin : g_head
      assign side_d = '{valid: s1_valid_q, last: s1_last_q, tex_u: '0, tex_v: '0};
    end else if (p == uvsg_pkg::DivStages) begin : g_tex
      assign side_d = '{valid: side_q[p-1].valid, last: side_q[p-1].last,
                        tex_u: u_sat, tex_v: v_sat};
    end else begin : g_pass
      assign side_d = side_q[p-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[p] <= '0;
      end else if (adv) begin
        side_q[p] <= side_d;
      end
    end
  end

  // ---------------- sin / cos ----------------
  logic signed [15:0] sa, ca, se, ce;

  uvsg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_az (
    .clk_i (clk_i), .en_i (adv), .angle_i (az_ang), .sin_o (sa), .cos_o (ca)
  );

  uvsg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_el (
    .clk_i (clk_i), .en_i (adv), .angle_i (el_ang), .sin_o (se), .cos_o (ce)
  );

  // ---------------- M1: first products ----------------
  uvsg_pkg::side_t    m1_side_q;
  logic signed [31:0] m1_psa_q, m1_pca_q;
  logic signed [32:0] m1_pz_q;
  logic signed [15:0] m1_nz_q;
  logic signed [16:0] rad_s;

  assign rad_s = $signed({1'b0, radius_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_side_q <= '0;
    end else if (adv) begin
      m1_side_q <= side_q[PipeDepth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_psa_q <= se * sa;
      m1_pca_q <= se * ca;
      m1_pz_q  <= ce * rad_s;
      m1_nz_q  <= ce;
    end
  end

  // ---------------- M2: radius products, normals, z ----------------
  uvsg_pkg::side_t    m2_side_q;
  logic signed [48:0] m2_qx_q, m2_qy_q;
  logic signed [15:0] m2_nx_q, m2_ny_q, m2_nz_q;
  logic signed [16:0] m2_pz_q;
  logic signed [31:0] psa_r, pca_r;
  logic signed [32:0] pz_r;
  logic signed [31:0] nx_w, ny_w, pz_w;

  always_comb begin
    psa_r = m1_psa_q + 32'sd8192;
    pca_r = m1_pca_q + 32'sd8192;
    pz_r  = m1_pz_q + 33'sd8192;
    nx_w  = $signed(psa_r[31:14]);
    ny_w  = $signed(pca_r[31:14]);
    pz_w  = $signed(pz_r[32:14]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_side_q <= '0;
    end else if (adv) begin
      m2_side_q <= m1_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_qx_q <= m1_psa_q * rad_s;
      m2_qy_q <= m1_pca_q * rad_s;
      m2_nx_q <= uvsg_pkg::sat_unit(nx_w);
      m2_ny_q <= uvsg_pkg::sat_unit(ny_w);
      m2_nz_q <= m1_nz_q;
      m2_pz_q <= uvsg_pkg::sat_s17(pz_w);
    end
  end

  // ---------------- output register ----------------
  logic signed [48:0] qx_r, qy_r;
  logic signed [31:0] px_w, py_w;
  logic signed [16:0] o_px_q, o_py_q, o_pz_q;
  logic signed [15:0] o_nx_q, o_ny_q, o_nz_q;
  logic [15:0]        o_u_q, o_v_q;
  logic               o_last_q;

  always_comb begin
    qx_r = m2_qx_q + 49'sd134217728;
    qy_r = m2_qy_q + 49'sd134217728;
    px_w = $signed(qx_r[48:28]);
    py_w = $signed(qy_r[48:28]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= m2_side_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_px_q   <= uvsg_pkg::sat_s17(px_w);
      o_py_q   <= uvsg_pkg::sat_s17(py_w);
      o_pz_q   <= m2_pz_q;
      o_nx_q   <= m2_nx_q;
      o_ny_q   <= m2_ny_q;
      o_nz_q   <= m2_nz_q;
      o_u_q    <= m2_side_q.tex_u;
      o_v_q    <= m2_side_q.tex_v;
      o_last_q <= m2_side_q.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {5'd0, o_v_q, o_u_q, o_nz_q, o_ny_q, o_nx_q,
                          o_pz_q, o_py_q, o_px_q};

  // ---------------- assertions ----------------
  `UVSG_ASSERT_NOW(a_ready_only_when_free, s_axis_tready,
    (!busy_q || (k_q == uvsg_pkg::LAST_VTX)), "input taken while corners remain")
  `UVSG_ASSERT_NOW(a_corner_range, busy_q, (k_q <= uvsg_pkg::LAST_VTX),
    "corner counter out of range")
  `UVSG_ASSERT_NEXT(a_accept_starts, in_acc, (busy_q && (k_q == 3'd0)),
    "accepted item did not start at first corner")
  `UVSG_ASSERT_NEXT(a_last_marked, (adv && busy_q && (k_q == uvsg_pkg::LAST_VTX)),
    (s0_valid_q && s0_last_q), "sixth corner not marked last")

endmodule

// ===== dv/tb_uv_sphere_vertex_gen_unit.sv =====
`timescale 1ns / 100ps

module tb_uv_sphere_vertex_gen_unit;

  localparam int          NumStages   = 16;
  localparam int          DrainCycles = NumStages + 24;
  localparam int          StallLimit  = 3000;
  localparam logic [3:0]  CfgBadIdx   = 4'd13;

  localparam longint AtanTurn[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81};

  typedef struct {
    logic [16:0] pos_x, pos_y, pos_z;
    logic [15:0] norm_x, norm_y, norm_z;
    logic [15:0] tex_u, tex_v;
    logic        last;
  } vertex_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [3:0]   cfg_addr_i;
  logic [15:0]  cfg_wdata_i;

  // predictor copy of the registers
  int unsigned divisions_r, radius_r, tex_w_r, tex_h_r;

  vertex_t vertex_q[$];
  int      mismatches;
  int      idle_pct;
  int      stall_pct;
  int      hold_req;
  int      quiet_cycles;

  uv_sphere_vertex_gen_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic void sin_cos_q14(input logic [31:0] ang, output longint s,
                                      output longint c);
    longint x, y, z, dx, dy, cq, sq;
    x = 652032874;
    y = 0;
    z = longint'(ang[29:0]);
    for (int k = 0; k < NumStages; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTurn[k];
      end else begin
        x += dx; y -= dy; z += AtanTurn[k];
      end
    end
    cq = clip(rnd_shift(x, 16), -16384, 16384);
    sq = clip(rnd_shift(y, 16), -16384, 16384);
    case (ang[31:30])
      2'd0: begin c = cq;  s = sq;  end
      2'd1: begin c = -sq; s = cq;  end
      2'd2: begin c = -cq; s = -sq; end
      default: begin c = sq; s = -cq; end
    endcase
  endfunction

  function automatic vertex_t corner_vertex(int unsigned d, int unsigned i, int unsigned j);
    vertex_t v;
    longint unsigned rows, az_den, el_den, q, u, w;
    logic [31:0] az, el;
    longint sa, ca, se, ce, r;
    rows   = d / 2;
    az_den = d - 1;
    el_den = rows - 1;
    q  = ((longint'(i) << 32) + (az_den >> 1)) / az_den;
    az = q[31:0];
    q  = ((longint'(j) << 31) + (el_den >> 1)) / el_den;
    el = q[31:0];
    sin_cos_q14(az, sa, ca);
    sin_cos_q14(el, se, ce);
    r = radius_r;
    v.pos_x  = 17'(clip(rnd_shift(se * sa * r, 28), -65536, 65535));
    v.pos_y  = 17'(clip(rnd_shift(se * ca * r, 28), -65536, 65535));
    v.pos_z  = 17'(clip(rnd_shift(ce * r, 14), -65536, 65535));
    v.norm_x = 16'(clip(rnd_shift(se * sa, 14), -16384, 16384));
    v.norm_y = 16'(clip(rnd_shift(se * ca, 14), -16384, 16384));
    v.norm_z = 16'(clip(ce, -16384, 16384));
    u = (longint'(i) * tex_w_r * 16 + d / 2) / d;
    w = (longint'(j) * tex_h_r * 16 + rows / 2) / rows;
    v.tex_u  = u > 65535 ? 16'hFFFF : u[15:0];
    v.tex_v  = w > 65535 ? 16'hFFFF : w[15:0];
    v.last   = 1'b0;
    return v;
  endfunction

  // six corners of a quad, in triangle order
  function automatic void predict_quad(int unsigned col, int unsigned row);
    int unsigned d, rows, c, r;
    vertex_t v;
    d    = divisions_r < 4 ? 4 : divisions_r;
    rows = d / 2;
    c    = col >= d ? d - 1 : col;
    r    = row >= rows ? rows - 1 : row;
    for (int k = 0; k < 6; k++) begin
      v = corner_vertex(d, c + ((k == 0 || k >= 4) ? 1 : 0),
                        r + ((k >= 2 && k <= 4) ? 1 : 0));
      v.last = (k == 5);
      vertex_q.push_back(v);
    end
  endfunction

  task automatic send_quad(int unsigned col, int unsigned row);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, row[7:0], col[8:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_quad(col[8:0], row[7:0]);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (vertex_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      uvsg_pkg::CFG_DIVISIONS:  divisions_r = val[8:0];
      uvsg_pkg::CFG_RADIUS:     radius_r    = val;
      uvsg_pkg::CFG_TEX_WIDTH:  tex_w_r     = val[11:0];
      uvsg_pkg::CFG_TEX_HEIGHT: tex_h_r     = val[11:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [15:0] d, logic [15:0] rad, logic [15:0] tw, logic [15:0] th);
    write_reg(uvsg_pkg::CFG_DIVISIONS, d);
    write_reg(uvsg_pkg::CFG_RADIUS, rad);
    write_reg(uvsg_pkg::CFG_TEX_WIDTH, tw);
    write_reg(uvsg_pkg::CFG_TEX_HEIGHT, th);
  endtask

  task automatic send_random(int n);
    int unsigned d;
    for (int k = 0; k < n; k++) begin
      d = divisions_r < 4 ? 4 : divisions_r;
      if ($urandom_range(9) < 8) begin
        send_quad($urandom_range(d - 1), $urandom_range(d / 2 - 1));
      end else begin
        send_quad($urandom_range(511), $urandom_range(255));
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_quad(0, 0);
    send_quad(359, 179);
    send_quad(90, 45);
    drain();
  endtask

  task automatic test_grid_extremes();
    set_grid(16'd36, 16'd64, 16'd4095, 16'd4095);
    send_quad(0, 0);
    send_quad(35, 17);
    send_quad(511, 255);   // both saturate to the last quad
    send_quad(9, 4);
    drain();
    set_grid(16'd511, 16'hFFFF, 16'd1, 16'd4095);
    send_quad(0, 0);
    send_quad(510, 254);
    send_quad(256, 128);
    send_quad(127, 63);
    drain();
    // masked upper bits; divisions below four act as four
    set_grid(16'hFE02, 16'd64000, 16'hF000, 16'hFFFF);
    send_quad(0, 0);
    send_quad(3, 1);
    drain();
    write_reg(uvsg_pkg::CFG_DIVISIONS, 16'd0);
    send_quad(1, 0);
    drain();
    write_reg(uvsg_pkg::CFG_DIVISIONS, 16'd5);
    write_reg(CfgBadIdx, 16'hFFFF);   // ignored
    send_quad(4, 2);
    send_quad(2, 1);
    drain();
  endtask

  task automatic test_random_phases();
    int idle_set[4]  = '{0, 83, 0, 14};
    int stall_set[4] = '{0, 0, 83, 14};
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      set_grid(16'($urandom_range(511, 36)), 16'($urandom_range(65535, 64)),
               16'($urandom_range(4095)), 16'($urandom_range(4095)));
      send_random(25);
      drain();
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  task automatic test_output_hold();
    set_grid(16'd360, 16'd6400, 16'd1024, 16'd512);
    hold_req = 400;
    send_random(20);
    drain();
  endtask

  // receiver side, with its own long hold-off count
  initial begin
    int hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    vertex_t got, exp_v;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.pos_x  = m_axis_tdata[16:0];
      got.pos_y  = m_axis_tdata[33:17];
      got.pos_z  = m_axis_tdata[50:34];
      got.norm_x = m_axis_tdata[66:51];
      got.norm_y = m_axis_tdata[82:67];
      got.norm_z = m_axis_tdata[98:83];
      got.tex_u  = m_axis_tdata[114:99];
      got.tex_v  = m_axis_tdata[130:115];
      got.last   = m_axis_tlast;
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex %p", got);
      end else begin
        exp_v = vertex_q.pop_front();
        if (got.pos_x !== exp_v.pos_x || got.pos_y !== exp_v.pos_y ||
            got.pos_z !== exp_v.pos_z || got.norm_x !== exp_v.norm_x ||
            got.norm_y !== exp_v.norm_y || got.norm_z !== exp_v.norm_z ||
            got.tex_u !== exp_v.tex_u || got.tex_v !== exp_v.tex_v ||
            got.last !== exp_v.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("vertex mismatch: expected %p", exp_v);
            $display("                 actual   %p", got);
          end
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("uv_sphere_vertex_gen_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    mismatches    = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_req      = 0;
    quiet_cycles  = 0;
    divisions_r   = 360;
    radius_r      = 6400;
    tex_w_r       = 0;
    tex_h_r       = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_grid_extremes();
    test_random_phases();
    test_output_hold();

    if (mismatches == 0 && vertex_q.size() == 0) begin
      $display("uv_sphere_vertex_gen_unit regression: pass");
    end else begin
      $display("uv_sphere_vertex_gen_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== uv_sphere_vertex_gen_unit.f =====
+incdir+hdl
hdl/uvsg_pkg.sv
hdl/uvsg_div.sv
hdl/uvsg_cordic.sv
hdl/uv_sphere_vertex_gen_unit.sv
dv/tb_uv_sphere_vertex_gen_unit.sv
